/* rtl/qst_dec_pkg.sv */
// Package for the smallest-three quaternion decoder.
// Holds the pipeline payload types, fixed constants and the square root step.
// No dependencies.
package qst_dec_pkg;

  // Bitwise square root: 16 result bits, four of them resolved in each stage.
  localparam int ROOT_STEPS      = 16;
  localparam int STEPS_PER_STAGE = 4;
  localparam int ROOT_STAGES     = ROOT_STEPS / STEPS_PER_STAGE;

  // One in Q2.30, the squared norm of a unit quaternion.
  localparam logic [31:0] UNIT_SQ  = 32'h4000_0000;
  // Saturation limits of a Q1.15 component.
  localparam logic [15:0] NEG_FULL = 16'h8000;
  localparam logic [15:0] POS_FULL = 16'h7FFF;

  // Positions of the four quaternion components.
  localparam logic [1:0] POS_W = 2'd0;
  localparam logic [1:0] POS_X = 2'd1;
  localparam logic [1:0] POS_Y = 2'd2;
  localparam logic [1:0] POS_Z = 2'd3;

  // Side data that travels with an item through the stages before the output register.
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [1:0]  idx;
    logic        neg;
  } meta_t;

  // Working state of the restoring square root.
  typedef struct packed {
    logic [31:0] radicand;
    logic [18:0] rem;
    logic [15:0] root;
  } root_t;

  // One restoring step: bring down two radicand bits and try root*4+1.
  function automatic root_t root_step(root_t s);
    root_t       r;
    logic [18:0] rem_sh;
    logic [18:0] trial;
    rem_sh     = {s.rem[16:0], s.radicand[31:30]};
    trial      = 19'({s.root, 2'b01});
    r.radicand = {s.radicand[29:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {s.root[14:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {s.root[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/qst_dec_if.sv */
// Channel interfaces of the smallest-three quaternion decoder.
// Valid/ready channels for the packed input item and the rebuilt quaternion.
// No dependencies.
interface qst_dec_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] part_a;
  logic [14:0] part_b;
  logic [14:0] part_c;
  logic [1:0]  largest_index;
  logic        largest_negative;

  modport source (output valid, part_a, part_b, part_c, largest_index, largest_negative,
                  input ready);
  modport sink (input valid, part_a, part_b, part_c, largest_index, largest_negative,
                output ready);
endinterface

interface qst_dec_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] comp_w;
  logic signed [15:0] comp_x;
  logic signed [15:0] comp_y;
  logic signed [15:0] comp_z;

  modport source (output valid, comp_w, comp_x, comp_y, comp_z, input ready);
  modport sink (input valid, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

/* rtl/quaternion_smallest_three_decoder_core.sv */
// Smallest-three quaternion decoder, top level.
// Depends on qst_dec_pkg and the channel interfaces in qst_dec_if.sv.
//
// Usage:
//   packed_q carries one compressed quaternion per transfer: three kept parts,
//   the position of the dropped component and its sign. quat carries the
//   rebuilt Q1.15 quaternion, one result for every input transfer, in order.
//   Both channels transfer on a clock edge where valid and ready are high.
//
// Pipeline and throughput:
//   The transfer edge loads the first of seven register stages: one stage
//   squares the parts, one sums them and forms the radicand, four stages each
//   resolve four bits of the 16-bit square root, and the output register
//   places the components. One item is taken per cycle while quat is not
//   stalled.
//
// Reset and stalls:
//   rst (synchronous, active high) empties every stage; nothing else is kept
//   between items. When quat is stalled, each stage holds only while the stage
//   after it is full, so bubbles close up and the input keeps taking items
//   until all seven stages are full.
module quaternion_smallest_three_decoder_core #(
  parameter int DROP_SHIFT = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  qst_dec_in_if.sink           packed_q,
  qst_dec_out_if.source        quat
);
  import qst_dec_pkg::*;

  // Stage 0 squares, stage 1 sums, then root stages, then the output register.
  localparam int NSTG = ROOT_STAGES + 3;
  localparam int OUT  = NSTG - 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  meta_t        md [0:NSTG-2];
  root_t        rt [0:ROOT_STAGES];
  logic [30:0]  sq_a;
  logic [30:0]  sq_b;
  logic [30:0]  sq_c;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    rdy[OUT] = !vld[OUT] || quat.ready;
    for (int i = OUT - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign packed_q.ready = rdy[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= packed_q.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Widen each part: shift left and keep the low 16 bits as a signed value.
  logic signed [15:0] wa;
  logic signed [15:0] wb;
  logic signed [15:0] wc;
  logic signed [31:0] pa;
  logic signed [31:0] pb;
  logic signed [31:0] pc;

  assign wa = $signed(16'(32'(packed_q.part_a) << DROP_SHIFT));
  assign wb = $signed(16'(32'(packed_q.part_b) << DROP_SHIFT));
  assign wc = $signed(16'(32'(packed_q.part_c) << DROP_SHIFT));
  assign pa = wa * wa;
  assign pb = wb * wb;
  assign pc = wc * wc;

  // Stage 0: squares of the widened parts.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sq_a      <= pa[30:0];
      sq_b      <= pb[30:0];
      sq_c      <= pc[30:0];
      md[0].a   <= wa;
      md[0].b   <= wb;
      md[0].c   <= wc;
      md[0].idx <= packed_q.largest_index;
      md[0].neg <= packed_q.largest_negative;
    end
  end

  // Stage 1: sum of squares and the radicand one minus that sum.
  logic [31:0] sum;
  assign sum = 32'(sq_a) + 32'(sq_b) + 32'(sq_c);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      rt[0].radicand <= (sum < UNIT_SQ) ? (UNIT_SQ - sum) : '0;
      rt[0].rem      <= '0;
      rt[0].root     <= '0;
      md[1]          <= md[0];
    end
  end

  // Root stages: each resolves STEPS_PER_STAGE result bits.
  for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
    root_t chain [0:STEPS_PER_STAGE];

    always_comb begin
      chain[0] = rt[g];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        chain[j+1] = root_step(chain[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[2+g]) begin
        rt[g+1]  <= chain[STEPS_PER_STAGE];
        md[2+g]  <= md[1+g];
      end
    end
  end

  // Output stage: sign and saturate the dropped component, then place it.
  meta_t       mo;
  logic [15:0] mag;
  logic [15:0] dropped;

  assign mo  = md[NSTG-2];
  assign mag = rt[ROOT_STAGES].root;

  always_comb begin
    if (mo.neg) begin
      dropped = mag[15] ? NEG_FULL : 16'(-mag);
    end else begin
      dropped = mag[15] ? POS_FULL : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[OUT]) begin
      case (mo.idx)
        POS_W: begin
          quat.comp_w <= dropped;
          quat.comp_x <= mo.a;
          quat.comp_y <= mo.b;
          quat.comp_z <= mo.c;
        end
        POS_X: begin
          quat.comp_w <= mo.a;
          quat.comp_x <= dropped;
          quat.comp_y <= mo.b;
          quat.comp_z <= mo.c;
        end
        POS_Y: begin
          quat.comp_w <= mo.a;
          quat.comp_x <= mo.b;
          quat.comp_y <= dropped;
          quat.comp_z <= mo.c;
        end
        default: begin
          quat.comp_w <= mo.a;
          quat.comp_x <= mo.b;
          quat.comp_y <= mo.c;
          quat.comp_z <= dropped;
        end
      endcase
    end
  end

  assign quat.valid = vld[OUT];

  // The pipeline is empty on the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  // An empty output register lets the whole chain advance.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[OUT] |-> packed_q.ready)
    else $error("input stalled with empty output register");

  // A stalled root result is held, never dropped.
  a_root_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTG-2] && !rdy[NSTG-2]) |=> vld[NSTG-2])
    else $error("stalled root stage lost its item");

  // The finished root never exceeds one, and its remainder stays within 2*root.
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-2] |-> ((mag <= NEG_FULL) &&
                     (rt[ROOT_STAGES].rem <= 19'({mag, 1'b0}))))
    else $error("square root result out of range");

endmodule

/* tb/qst_dec_quat_checker.sv */
// Checker for the smallest-three quaternion decoder.
// It watches both channels, rebuilds each expected quaternion, and compares
// the four components. Depends on qst_dec_pkg and the interfaces in qst_dec_if.sv.
module qst_dec_quat_checker #(
  parameter int DROP_SHIFT = 1
) (
  input  logic   clk,
  input  logic   rst,
  qst_dec_in_if  in_ch,
  qst_dec_out_if out_ch,
  output int     fail_count,
  output int     checked_count
);
  import qst_dec_pkg::*;

  // Components are indexed by position: 0 is w, 3 is z.
  typedef logic [3:0][15:0] quat_t;

  quat_t expected_quats[$];
  string comp_names[4] = '{"comp_w", "comp_x", "comp_y", "comp_z"};

  // A kept part is widened to 16 bits; bits shifted past bit 15 are lost.
  function automatic logic [15:0] widen_part(logic [14:0] part);
    logic [31:0] wide;
    wide = 32'(part) << DROP_SHIFT;
    return wide[15:0];
  endfunction

  // Floor square root, resolved one bit at a time from the top.
  function automatic logic [15:0] floor_sqrt(logic [31:0] n);
    logic [15:0] root;
    logic [15:0] cand;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = root | (16'd1 << b);
      if (64'(cand) * 64'(cand) <= 64'(n)) begin
        root = cand;
      end
    end
    return root;
  endfunction

  // Rebuilds the full quaternion from its compressed form.
  function automatic quat_t rebuild_quat(logic [14:0] part_a, logic [14:0] part_b,
                                         logic [14:0] part_c, logic [1:0] idx,
                                         logic neg);
    logic [15:0] kept[3];
    logic [31:0] norm_sq;
    logic [31:0] mag_abs;
    logic [15:0] mag;
    logic [15:0] dropped;
    int          v;
    int          p;
    quat_t       q;
    kept[0] = widen_part(part_a);
    kept[1] = widen_part(part_b);
    kept[2] = widen_part(part_c);
    norm_sq = '0;
    for (int k = 0; k < 3; k++) begin
      v       = int'(signed'(kept[k]));
      mag_abs = (v < 0) ? 32'(-v) : 32'(v);
      norm_sq = norm_sq + mag_abs * mag_abs;
    end
    mag = (norm_sq >= UNIT_SQ) ? 16'd0 : floor_sqrt(UNIT_SQ - norm_sq);
    // A root of exactly one does not fit Q1.15 and saturates.
    if (neg) begin
      dropped = (mag >= 16'h8000) ? NEG_FULL : 16'(-int'(mag));
    end else begin
      dropped = (mag >= 16'h8000) ? POS_FULL : mag;
    end
    p = 0;
    for (int k = 0; k < 4; k++) begin
      if (2'(k) == idx) begin
        q[k] = dropped;
      end else begin
        q[k] = kept[p];
        p++;
      end
    end
    return q;
  endfunction

  // Compare each output transfer with the oldest prediction, then record
  // the prediction for a new input transfer.
  always @(posedge clk) begin
    quat_t got;
    quat_t want;
    int    errs;
    if (rst) begin
      fail_count    <= 0;
      checked_count <= 0;
      expected_quats.delete();
    end else begin
      errs = 0;
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.comp_z, out_ch.comp_y, out_ch.comp_x, out_ch.comp_w};
        if (expected_quats.size() == 0) begin
          $error("quaternion transfer with none expected: w=%0d x=%0d y=%0d z=%0d",
                 $signed(got[POS_W]), $signed(got[POS_X]), $signed(got[POS_Y]),
                 $signed(got[POS_Z]));
          errs++;
        end else begin
          want = expected_quats.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k]) begin
              $error("%s: expected %0d, actual %0d", comp_names[k],
                     $signed(want[k]), $signed(got[k]));
              errs++;
            end
          end
          checked_count <= checked_count + 1;
        end
      end
      fail_count <= fail_count + errs;
      if (in_ch.valid && in_ch.ready) begin
        expected_quats.push_back(rebuild_quat(in_ch.part_a, in_ch.part_b, in_ch.part_c,
                                              in_ch.largest_index,
                                              in_ch.largest_negative));
      end
    end
  end

endmodule

/* tb/quaternion_smallest_three_decoder_core_tb.sv */
// Testbench top for the smallest-three quaternion decoder.
// Drives compressed quaternions under several pacing phases and gives the verdict.
// Depends on qst_dec_pkg, qst_dec_if.sv and qst_dec_quat_checker.
module quaternion_smallest_three_decoder_core_tb;
  import qst_dec_pkg::*;

  localparam int DROP_SHIFT    = 1;
  localparam int PHASE_ITEMS   = 440;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   checked_count;
  int   sent_count;
  int   directed_count;
  int   cycle_count;
  int   idle_pct;
  int   stall_pct;

  qst_dec_in_if  in_ch ();
  qst_dec_out_if out_ch ();

  quaternion_smallest_three_decoder_core #(
    .DROP_SHIFT (DROP_SHIFT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .packed_q (in_ch),
    .quat     (out_ch)
  );

  qst_dec_quat_checker #(
    .DROP_SHIFT (DROP_SHIFT)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .checked_count (checked_count)
  );

  // Clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver side: ready drops at random at the current stall rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // One input transfer, after a random number of idle cycles.
  task automatic send_item(logic [14:0] part_a, logic [14:0] part_b, logic [14:0] part_c,
                           logic [1:0] idx, logic neg);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.part_a           <= part_a;
    in_ch.part_b           <= part_b;
    in_ch.part_c           <= part_c;
    in_ch.largest_index    <= idx;
    in_ch.largest_negative <= neg;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    sent_count++;
  endtask

  // Mostly parts of a plausible unit quaternion, the rest raw noise.
  task automatic send_random();
    logic [14:0] parts[3];
    int          v;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(99) < 65) begin
        v        = int'($urandom_range(36000)) - 18000;
        parts[k] = 15'(v >>> DROP_SHIFT);
      end else begin
        parts[k] = 15'($urandom);
      end
    end
    send_item(parts[0], parts[1], parts[2], 2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // Stop sending and let every expected quaternion arrive.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (checked_count != sent_count);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hard limit on the run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("quaternion_smallest_three_decoder_core regression: fail");
    $finish;
  end

  // Stimulus: directed corners, then four pacing phases of random items.
  initial begin
    sent_count             = 0;
    idle_pct               = 0;
    stall_pct              = 0;
    rst                    <= 1'b1;
    in_ch.valid            <= 1'b0;
    in_ch.part_a           <= '0;
    in_ch.part_b           <= '0;
    in_ch.part_c           <= '0;
    in_ch.largest_index    <= POS_W;
    in_ch.largest_negative <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // All parts zero: the root is exactly one and saturates, at every position.
    for (int k = 0; k < 4; k++) begin
      send_item('0, '0, '0, 2'(k), 1'b0);
      send_item('0, '0, '0, 2'(k), 1'b1);
    end
    // Full-scale negative part: its square alone reaches one, so the root is zero.
    send_item(15'h4000, '0, '0, POS_X, 1'b1);
    send_item('0, 15'h4000, 15'h4000, POS_Y, 1'b0);
    // Largest positive parts overflow the norm.
    send_item(15'h3FFF, 15'h3FFF, 15'h3FFF, POS_Z, 1'b1);
    // One large part leaves a small root.
    send_item(15'h3FFF, '0, '0, POS_W, 1'b0);
    // All ones is a small negative value after the shift.
    send_item(15'h7FFF, 15'h7FFF, 15'h7FFF, POS_X, 1'b0);
    // Three halves squared stay below one.
    send_item(15'h2000, 15'h2000, 15'h2000, POS_Y, 1'b1);
    send_item(15'h6000, 15'h2000, 15'h6000, POS_Z, 1'b0);
    // Alternating bit patterns.
    send_item(15'h5555, 15'h2AAA, 15'h5555, POS_W, 1'b1);
    send_item(15'h2AAA, 15'h5555, 15'h2AAA, POS_Z, 1'b0);
    // Small magnitudes: the norm is near zero, so the root is near one.
    send_item(15'h0001, 15'h7FFF, 15'h0001, POS_X, 1'b1);
    directed_count = sent_count;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  = 72;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 72;
        end
        default: begin
          idle_pct  = 17;
          stall_pct <= 17;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random();
      end
      // The sender holds off until every quaternion of the phase has come back.
      wait_drained();
    end

    $display("Sent %0d compressed quaternions (%0d directed corners) over four pacing phases;",
             sent_count, directed_count);
    $display("compared %0d rebuilt quaternions component by component.", checked_count);
    if (fail_count == 0) begin
      $display("quaternion_smallest_three_decoder_core regression: pass");
    end else begin
      $display("quaternion_smallest_three_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
